[src/cgd_pkg.sv]
// ----------------------------------------------------------------------------
// Drawing engine package
// Shared types and constants for the rectangle and glyph drawing engine.
// ----------------------------------------------------------------------------
package cgd_pkg;

   localparam int MODE_W   = 3;
   localparam int GEO_W    = 14;
   localparam int COORD_W  = 11;
   localparam int INDEX_W  = 14;
   localparam int GCNT_W   = 3;

   localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PIXEL = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RECT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CHAR  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

   typedef struct packed {
      logic               read;
      logic               last;
      logic               skip;
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] y0;
      logic [COORD_W-1:0] xlen;
      logic [COORD_W-1:0] ylen;
      logic [7:0]         color;
      logic [INDEX_W-1:0] word_index;
   } op_type;

endpackage

[src/cgd_front.sv]
// ----------------------------------------------------------------------------
// Drawing engine front end
// Takes one command, clips it to the screen and splits glyphs into cell fills.
// ----------------------------------------------------------------------------
module cgd_front #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 120,
   parameter int GLYPH_COLUMNS = 5,
   parameter int GLYPH_ROWS    = 7
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 back_init,
   input  logic                                 push,
   output logic                                 full,
   input  logic [cgd_pkg::MODE_W-1:0]           req_mode,
   input  logic signed [10:0]                   req_x_pos,
   input  logic signed [10:0]                   req_y_pos,
   input  logic signed [10:0]                   req_width_px,
   input  logic signed [10:0]                   req_height_px,
   input  logic [7:0]                           req_color,
   input  logic [7:0]                           req_fg_color,
   input  logic [7:0]                           req_bg_color,
   input  logic [3:0]                           req_scale,
   input  logic [GLYPH_COLUMNS*GLYPH_ROWS-1:0]  req_glyph_bits,
   input  logic [cgd_pkg::INDEX_W-1:0]          req_word_index,
   input  logic                                 q_full,
   output logic                                 q_push,
   output cgd_pkg::op_type                      q_data
);
   import cgd_pkg::*;

   localparam int BITS_W = GLYPH_COLUMNS * GLYPH_ROWS;

   logic                      busy_ff, busy_in;
   logic                      glyph_ff, glyph_in;
   logic                      read_ff, read_in;
   logic                      skip_ff, skip_in;
   logic signed [GEO_W-1:0]   gx_ff, gx_in;
   logic signed [GEO_W-1:0]   gy_ff, gy_in;
   logic signed [GEO_W-1:0]   gw_ff, gw_in;
   logic signed [GEO_W-1:0]   gh_ff, gh_in;
   logic signed [GEO_W-1:0]   ybase_ff, ybase_in;
   logic [7:0]                color_ff, color_in;
   logic [7:0]                fg_ff, fg_in;
   logic [7:0]                bg_ff, bg_in;
   logic [BITS_W-1:0]         bits_ff, bits_in;
   logic [GCNT_W-1:0]         col_ff, col_in;
   logic [GCNT_W-1:0]         row_ff, row_in;
   logic [INDEX_W-1:0]        index_ff, index_in;

   logic                      accept;
   logic                      cell_last;
   logic signed [GEO_W-1:0]   xs, xe, ys, ye, x1, y1;
   logic                      clip_empty;
   logic signed [GEO_W-1:0]   scale_eff;

   assign full   = busy_ff | back_init;
   assign accept = push & ~full;
   assign q_push = busy_ff & ~q_full;

   assign scale_eff = (req_scale == 4'd0) ? GEO_W'(1) : GEO_W'(req_scale);
   assign cell_last = (col_ff == GCNT_W'(GLYPH_COLUMNS - 1)) &&
                      (row_ff == GCNT_W'(GLYPH_ROWS - 1));

   always_comb begin
      x1 = gx_ff + gw_ff;
      y1 = gy_ff + gh_ff;
      xs = (gx_ff < 0) ? '0 : gx_ff;
      ys = (gy_ff < 0) ? '0 : gy_ff;
      xe = (x1 > GEO_W'(SCREEN_WIDTH)) ? GEO_W'(SCREEN_WIDTH) : x1;
      ye = (y1 > GEO_W'(SCREEN_HEIGHT)) ? GEO_W'(SCREEN_HEIGHT) : y1;
      clip_empty = (xe <= xs) || (ye <= ys);
   end

   always_comb begin
      q_data.read       = read_ff;
      q_data.last       = glyph_ff ? cell_last : 1'b1;
      q_data.skip       = skip_ff | clip_empty;
      q_data.x0         = xs[COORD_W-1:0];
      q_data.y0         = ys[COORD_W-1:0];
      q_data.xlen       = COORD_W'(xe - xs);
      q_data.ylen       = COORD_W'(ye - ys);
      q_data.color      = glyph_ff ? (bits_ff[0] ? fg_ff : bg_ff) : color_ff;
      q_data.word_index = index_ff;
   end

   always_comb begin
      busy_in  = busy_ff;
      glyph_in = glyph_ff;
      read_in  = read_ff;
      skip_in  = skip_ff;
      gx_in    = gx_ff;
      gy_in    = gy_ff;
      gw_in    = gw_ff;
      gh_in    = gh_ff;
      ybase_in = ybase_ff;
      color_in = color_ff;
      fg_in    = fg_ff;
      bg_in    = bg_ff;
      bits_in  = bits_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      index_in = index_ff;
      if (accept) begin
         busy_in  = 1'b1;
         glyph_in = 1'b0;
         read_in  = 1'b0;
         skip_in  = 1'b0;
         gx_in    = GEO_W'(req_x_pos);
         gy_in    = GEO_W'(req_y_pos);
         ybase_in = GEO_W'(req_y_pos);
         gw_in    = GEO_W'(req_width_px);
         gh_in    = GEO_W'(req_height_px);
         color_in = req_color;
         fg_in    = req_fg_color;
         bg_in    = req_bg_color;
         bits_in  = req_glyph_bits;
         col_in   = '0;
         row_in   = '0;
         index_in = req_word_index;
         case (req_mode)
            MODE_CLEAR: begin
               gx_in = '0;
               gy_in = '0;
               gw_in = GEO_W'(SCREEN_WIDTH);
               gh_in = GEO_W'(SCREEN_HEIGHT);
            end
            MODE_PIXEL: begin
               gw_in = GEO_W'(1);
               gh_in = GEO_W'(1);
            end
            MODE_RECT: begin
            end
            MODE_CHAR: begin
               glyph_in = 1'b1;
               gw_in    = scale_eff;
               gh_in    = scale_eff;
            end
            MODE_READ: begin
               read_in = 1'b1;
               skip_in = 1'b1;
            end
            default: begin
               skip_in = 1'b1;
            end
         endcase
      end else if (q_push) begin
         if (!glyph_ff || cell_last) begin
            busy_in = 1'b0;
         end else begin
            bits_in = bits_ff >> 1;
            if (row_ff == GCNT_W'(GLYPH_ROWS - 1)) begin
               row_in = '0;
               col_in = col_ff + GCNT_W'(1);
               gy_in  = ybase_ff;
               gx_in  = gx_ff + gw_ff;
            end else begin
               row_in = row_ff + GCNT_W'(1);
               gy_in  = gy_ff + gh_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      glyph_ff <= glyph_in;
      read_ff  <= read_in;
      skip_ff  <= skip_in;
      gx_ff    <= gx_in;
      gy_ff    <= gy_in;
      gw_ff    <= gw_in;
      gh_ff    <= gh_in;
      ybase_ff <= ybase_in;
      color_ff <= color_in;
      fg_ff    <= fg_in;
      bg_ff    <= bg_in;
      bits_ff  <= bits_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      index_ff <= index_in;
   end

endmodule

[src/cgd_queue.sv]
// ----------------------------------------------------------------------------
// Drawing engine operation queue
// Four-entry queue of clipped drawing operations between front and back.
// ----------------------------------------------------------------------------
module cgd_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  cgd_pkg::op_type push_data,
   output logic            full,
   input  logic            pop,
   output logic            empty,
   output cgd_pkg::op_type head
);
   import cgd_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = 2;

   op_type           slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (PTR_W + 1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_in    = do_push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in    = do_pop ? rd_ff + PTR_W'(1) : rd_ff;
      count_in = count_ff + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

[src/cgd_back.sv]
// ----------------------------------------------------------------------------
// Drawing engine back end
// Fills clipped rectangles word by word into the frame store, serves reads.
// ----------------------------------------------------------------------------
module cgd_back #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 120
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   input  cgd_pkg::op_type q_head,
   output logic            q_pop,
   output logic            init_busy,
   input  logic            pop,
   output logic            empty,
   output logic [31:0]     rsp_read_data,
   output logic            rsp_was_read
);
   import cgd_pkg::*;

   localparam int BYTES = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int WORDS = (BYTES + 3) / 4;
   localparam int AW    = $clog2(WORDS);
   localparam int BW    = $clog2(BYTES + 2 * SCREEN_WIDTH + 8);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_RUN   = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_CAPT  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic               init_ff, init_in;
   op_type             op_ff, op_in;
   logic [BW-1:0]      row_ff, row_in;
   logic [BW-1:0]      end_ff, end_in;
   logic [BW-3:0]      word_ff, word_in;
   logic [COORD_W-1:0] rows_ff, rows_in;
   logic               hit_ff, hit_in;
   logic               valid_ff, valid_in;
   logic [31:0]        data_ff, data_in;
   logic               was_ff, was_in;
   logic [31:0]        rd_ff;

   logic               slot_free;
   logic [BW-1:0]      start_addr;
   logic [BW-1:0]      base_addr;
   logic [BW-1:0]      last_byte;
   logic [BW-1:0]      next_row;
   logic [3:0]         byte_en;
   logic               write_en;
   logic               read_en;
   logic [31:0]        index_wide;

   assign init_busy     = init_ff;
   assign empty         = ~valid_ff;
   assign rsp_read_data = data_ff;
   assign rsp_was_read  = was_ff;
   assign slot_free     = ~valid_ff | pop;
   assign q_pop         = (state_ff == ST_IDLE) & ~q_empty;
   assign index_wide    = 32'(op_ff.word_index);

   assign start_addr = BW'(op_ff.y0 * BW'(SCREEN_WIDTH)) + BW'(op_ff.x0);
   assign base_addr  = {word_ff, 2'b00};
   assign last_byte  = end_ff - BW'(1);
   assign next_row   = row_ff + BW'(SCREEN_WIDTH);
   assign write_en   = (state_ff == ST_RUN);
   assign read_en    = (state_ff == ST_READ);

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         byte_en[k] = ((base_addr + BW'(k)) >= row_ff) && ((base_addr + BW'(k)) < end_ff);
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_lane
      logic [7:0] mem [WORDS];
      always_ff @(posedge clock) begin
         if (write_en && byte_en[k]) begin
            mem[word_ff[AW-1:0]] <= op_ff.color;
         end
         if (read_en) begin
            rd_ff[8*k +: 8] <= mem[index_wide[AW-1:0]];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      init_in  = init_ff;
      op_in    = op_ff;
      row_in   = row_ff;
      end_in   = end_ff;
      word_in  = word_ff;
      rows_in  = rows_ff;
      hit_in   = hit_ff;
      valid_in = valid_ff & ~pop;
      data_in  = data_ff;
      was_in   = was_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               op_in = q_head;
               if (q_head.read) begin
                  state_in = ST_READ;
               end else if (q_head.skip) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            row_in   = start_addr;
            end_in   = start_addr + BW'(op_ff.xlen);
            word_in  = start_addr[BW-1:2];
            rows_in  = op_ff.ylen;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (word_ff == last_byte[BW-1:2]) begin
               if (rows_ff == COORD_W'(1)) begin
                  state_in = ST_DONE;
               end else begin
                  row_in  = next_row;
                  end_in  = end_ff + BW'(SCREEN_WIDTH);
                  word_in = next_row[BW-1:2];
                  rows_in = rows_ff - COORD_W'(1);
               end
            end else begin
               word_in = word_ff + (BW - 2)'(1);
            end
         end
         ST_READ: begin
            hit_in   = (index_wide < 32'(WORDS));
            state_in = ST_CAPT;
         end
         ST_CAPT: begin
            if (slot_free) begin
               valid_in = 1'b1;
               data_in  = hit_ff ? rd_ff : 32'd0;
               was_in   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            init_in = 1'b0;
            if (!op_ff.last) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               valid_in = 1'b1;
               data_in  = 32'd0;
               was_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SETUP;
         init_ff       <= 1'b1;
         valid_ff      <= 1'b0;
         op_ff.read    <= 1'b0;
         op_ff.last    <= 1'b0;
         op_ff.skip    <= 1'b0;
         op_ff.x0      <= '0;
         op_ff.y0      <= '0;
         op_ff.xlen    <= COORD_W'(SCREEN_WIDTH);
         op_ff.ylen    <= COORD_W'(SCREEN_HEIGHT);
         op_ff.color   <= '0;
         op_ff.word_index <= '0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         valid_ff <= valid_in;
         op_ff    <= op_in;
      end
      row_ff  <= row_in;
      end_ff  <= end_in;
      word_ff <= word_in;
      rows_ff <= rows_in;
      hit_ff  <= hit_in;
      data_ff <= data_in;
      was_ff  <= was_in;
   end

endmodule

[src/clipped_rect_and_glyph_drawer_unit.sv]
// ----------------------------------------------------------------------------
// Clipped rectangle and glyph drawer
// Draws clears, pixels, clipped rectangles and scaled glyphs into an
// 8-bit-per-pixel frame store and answers packed four-pixel reads.
//
//   channel   handshake        payload
//   request   push / full      req_mode .. req_word_index
//   response  pop / empty      rsp_read_data, rsp_was_read
//
// The back end writes one store word per cycle, filling the touched words of each
// row in turn; a full clear touches SCREEN_WIDTH*SCREEN_HEIGHT/4 words. A glyph
// is drawn as one such fill for each of its cells.
// After reset the store is zeroed in the same way, and full stays high meanwhile.
// A waiting response stalls the back end only when the next one is ready.
// ----------------------------------------------------------------------------
module clipped_rect_and_glyph_drawer_unit #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 120,
   parameter int GLYPH_COLUMNS = 5,
   parameter int GLYPH_ROWS    = 7
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic [cgd_pkg::MODE_W-1:0]           req_mode,
   input  logic signed [10:0]                   req_x_pos,
   input  logic signed [10:0]                   req_y_pos,
   input  logic signed [10:0]                   req_width_px,
   input  logic signed [10:0]                   req_height_px,
   input  logic [7:0]                           req_color,
   input  logic [7:0]                           req_fg_color,
   input  logic [7:0]                           req_bg_color,
   input  logic [3:0]                           req_scale,
   input  logic [GLYPH_COLUMNS*GLYPH_ROWS-1:0]  req_glyph_bits,
   input  logic [cgd_pkg::INDEX_W-1:0]          req_word_index,
   input  logic                                 pop,
   output logic                                 empty,
   output logic [31:0]                          rsp_read_data,
   output logic                                 rsp_was_read
);
   import cgd_pkg::*;

   logic   back_init;
   logic   q_push, q_full, q_pop, q_empty;
   op_type q_in, q_head;

   cgd_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .GLYPH_COLUMNS (GLYPH_COLUMNS),
      .GLYPH_ROWS    (GLYPH_ROWS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .back_init      (back_init),
      .push           (push),
      .full           (full),
      .req_mode       (req_mode),
      .req_x_pos      (req_x_pos),
      .req_y_pos      (req_y_pos),
      .req_width_px   (req_width_px),
      .req_height_px  (req_height_px),
      .req_color      (req_color),
      .req_fg_color   (req_fg_color),
      .req_bg_color   (req_bg_color),
      .req_scale      (req_scale),
      .req_glyph_bits (req_glyph_bits),
      .req_word_index (req_word_index),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (q_in)
   );

   cgd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   cgd_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .init_busy     (back_init),
      .pop           (pop),
      .empty         (empty),
      .rsp_read_data (rsp_read_data),
      .rsp_was_read  (rsp_was_read)
   );

endmodule
